// ===== rtl/wis_pkg.sv =====
// Package for the weighted index sampler.
// Holds the shared types, operation and status codes and the state enum.
// No dependencies.
`default_nettype none

package wis_pkg;

  localparam int unsigned DVD_W   = 32;
  localparam int unsigned REM_W   = 30;
  localparam int unsigned WT_W    = 24;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned ST_W    = 2;
  localparam logic [REM_W-1:0] TOTAL_MAX = {REM_W{1'b1}};

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_DRAW   = 2'd2,
    OP_NONE   = 2'd3
  } wis_op_e;

  typedef enum logic [ST_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } wis_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_CMP
  } wis_state_e;

  typedef struct packed {
    logic             valid;
    logic [REM_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
  } wis_stage_t;

endpackage

`default_nettype wire

// ===== rtl/weighted_index_sampler.sv =====
// Weighted index sampler: clear and append give their result in the cycle after they
// are taken; a draw reduces the word in the division cell chain, then runs the search
// (at most ceil(log2(entry count)) steps, one table read and one compare each).
// One request is in work at a time.
// Reset clears count, total, mode and control; the table is not cleared and
// needs no clearing pass, only written entries are read.
`default_nettype none

module weighted_index_sampler
  import wis_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       operation_i,
  input  wire logic [WT_W-1:0]  weight_i,
  input  wire logic [DVD_W-1:0] random_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [IDX_W-1:0]      chosen_index_o,
  output logic [ST_W-1:0]       status_o
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  wis_state_e       state_q, state_d;
  logic             mode_q;
  logic [CW-1:0]    count_q, count_d;
  logic [REM_W-1:0] total_q, total_d;
  logic [IW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [REM_W-1:0] target_q, target_d;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] index_q, index_d;
  logic [ST_W-1:0]  status_q, status_d;

  logic [REM_W-1:0] mem [0:MAX_ENTRIES-1];
  logic [REM_W-1:0] rd_q;
  logic             mem_we, mem_re;
  logic [IW-1:0]    mid_c;
  logic [REM_W:0]   sum;
  logic [CW-1:0]    cnt_m1;
  logic             acc;
  logic             start;
  logic             chain_done;
  logic [REM_W-1:0] chain_rem;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign acc        = in_valid_i && !in_stall_o;
  assign start      = acc && (operation_i == OP_DRAW) &&
                      (count_q != '0) && (total_q != '0);

  wis_mod_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .word_i    (random_word_i),
    .divisor_i (total_q),
    .done_o    (chain_done),
    .rem_o     (chain_rem)
  );

  assign mid_c  = lo_q + ((hi_q - lo_q) >> 1);
  assign sum    = {1'b0, total_q} + {{(REM_W + 1 - WT_W){1'b0}}, weight_i};
  assign cnt_m1 = count_q - CW'(1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    total_d     = total_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    target_d    = target_q;
    out_valid_d = out_valid_q && out_stall_i;
    index_d     = index_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (operation_i)
            OP_CLEAR: begin
              count_d     = '0;
              total_d     = '0;
              out_valid_d = 1'b1;
              index_d     = '0;
              status_d    = STS_OK;
            end
            OP_APPEND: begin
              out_valid_d = 1'b1;
              index_d     = '0;
              if (count_q >= CW'(MAX_ENTRIES)) begin
                status_d = STS_FULL;
              end else begin
                status_d = STS_OK;
                if (mode_q) begin
                  total_d = {{(REM_W - WT_W){1'b0}}, weight_i};
                end else begin
                  total_d = sum[REM_W] ? TOTAL_MAX : sum[REM_W-1:0];
                end
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_DRAW: begin
              if (start) begin
                state_d = ST_MOD;
              end else begin
                out_valid_d = 1'b1;
                index_d     = '0;
                status_d    = STS_EMPTY;
              end
            end
            default: begin
              out_valid_d = 1'b1;
              index_d     = '0;
              status_d    = STS_OK;
            end
          endcase
        end
      end
      ST_MOD: begin
        if (chain_done) begin
          target_d = chain_rem;
          lo_d     = '0;
          hi_d     = cnt_m1[IW-1:0];
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (lo_q >= hi_q) begin
          out_valid_d = 1'b1;
          index_d     = IDX_W'(lo_q);
          status_d    = STS_OK;
          state_d     = ST_IDLE;
        end else begin
          mem_re  = 1'b1;
          mid_d   = mid_c;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        if (rd_q > target_q) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + IW'(1);
        end
        state_d = ST_CHECK;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    target_q <= target_d;
    index_q  <= index_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IW-1:0]] <= total_d;
    end
    if (mem_re) begin
      rd_q <= mem[mid_c];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_index_o = index_q;
  assign status_o       = status_q;

`ifndef SYNTH
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("request taken while a draw is in work");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ENTRIES))
    else $error("entry count above table depth");

  a_chain_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_done |-> (state_q == ST_MOD))
    else $error("remainder arrived outside the modulo wait");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ((lo_q <= mid_q) && (mid_q < hi_q)))
    else $error("search bounds out of order");

  a_draw_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && lo_q >= hi_q) |=> out_valid_q)
    else $error("finished draw gave no result");
`endif

endmodule

`default_nettype wire

// ===== rtl/wis_mod_cell.sv =====
// One restoring-division cell: takes one dividend bit into the remainder.
// Depends on wis_pkg.
`default_nettype none

module wis_mod_cell
  import wis_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire wis_stage_t       stage_i,
  input  wire logic [REM_W-1:0] divisor_i,
  output wis_stage_t            stage_o
);

  logic [REM_W:0]   shl;
  logic [REM_W:0]   diff;
  logic             ge;
  wis_stage_t       stage_d;
  logic             valid_q;
  logic [REM_W-1:0] rem_q;
  logic [DVD_W-1:0] dvd_q;

  always_comb begin
    shl           = {stage_i.rem, stage_i.dvd[DVD_W-1]};
    diff          = shl - {1'b0, divisor_i};
    ge            = shl >= {1'b0, divisor_i};
    stage_d.valid = stage_i.valid;
    stage_d.rem   = ge ? diff[REM_W-1:0] : shl[REM_W-1:0];
    stage_d.dvd   = {stage_i.dvd[DVD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= stage_d.rem;
    dvd_q <= stage_d.dvd;
  end

  assign stage_o = '{valid: valid_q, rem: rem_q, dvd: dvd_q};

endmodule

`default_nettype wire

// ===== rtl/wis_mod_chain.sv =====
// Chain of division cells that reduces a random word modulo the total.
// Depends on wis_pkg and wis_mod_cell.
`default_nettype none

module wis_mod_chain
  import wis_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] word_i,
  input  wire logic [REM_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [REM_W-1:0]      rem_o
);

  wis_stage_t stg [0:DVD_W];

  assign stg[0] = '{valid: start_i, rem: '0, dvd: word_i};

  for (genvar i = 0; i < DVD_W; i++) begin : g_cell
    wis_mod_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .stage_i   (stg[i]),
      .divisor_i (divisor_i),
      .stage_o   (stg[i+1])
    );
  end

  assign done_o = stg[DVD_W].valid;
  assign rem_o  = stg[DVD_W].rem;

endmodule

`default_nettype wire

// ===== test/wis_draw_checker.sv =====
// Checker for the weighted index sampler: watches the request, result and
// register channels, predicts each result from its own table copy and compares.
// Depends on wis_pkg for widths, operation and status codes.
`timescale 1ns / 1ps

module wis_draw_checker
  import wis_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [1:0]       operation_i,
  input  logic [WT_W-1:0]  weight_i,
  input  logic [DVD_W-1:0] random_word_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [IDX_W-1:0] chosen_index_i,
  input  logic [ST_W-1:0]  status_i,
  output int               pending_o,
  output int               fail_count_o
);

  typedef struct packed {
    logic [IDX_W-1:0] index;
    wis_status_e      status;
  } draw_result_t;

  logic [REM_W-1:0] cum_table [MAX_ENTRIES];
  int unsigned      entries;
  logic [REM_W-1:0] total;
  logic             cumulative_mode;
  draw_result_t     expected_draws [$];
  draw_result_t     oldest;

  task automatic report_mismatch(input string what);
    // hold the log short on a badly broken block
    if (fail_count_o < 50) $display("%0t ns: mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  task automatic predict_request(input wis_op_e op, input logic [WT_W-1:0] w,
                                 input logic [DVD_W-1:0] rw);
    draw_result_t     r;
    logic [REM_W:0]   sum;
    logic [DVD_W-1:0] reduced;
    int unsigned      lo, hi, mid;
    r.index  = '0;
    r.status = STS_OK;
    case (op)
      OP_CLEAR: begin
        entries = 0;
        total   = '0;
      end
      OP_APPEND: begin
        if (entries >= MAX_ENTRIES) begin
          r.status = STS_FULL;
        end else begin
          if (cumulative_mode) begin
            total = REM_W'(w);
          end else begin
            sum   = total + w;
            total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[REM_W-1:0];
          end
          cum_table[entries] = total;
          entries++;
        end
      end
      OP_DRAW: begin
        if (entries == 0 || total == '0) begin
          r.status = STS_EMPTY;
        end else begin
          reduced = rw % {2'b00, total};
          lo = 0;
          hi = entries - 1;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (cum_table[mid] > reduced) hi = mid;
            else lo = mid + 1;
          end
          r.index = IDX_W'(lo);
        end
      end
      default: ;
    endcase
    expected_draws = {expected_draws, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries         = 0;
      total           = '0;
      cumulative_mode = 1'b0;
      expected_draws.delete();
      pending_o       = 0;
      fail_count_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_draws.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: index %0d status %0d",
                                    chosen_index_i, status_i));
        end else begin
          oldest = expected_draws.pop_front();
          if (chosen_index_i !== oldest.index)
            report_mismatch($sformatf("chosen_index got %0d, want %0d",
                                      chosen_index_i, oldest.index));
          if (status_i !== oldest.status)
            report_mismatch($sformatf("status got %0d, want %0d", status_i, oldest.status));
        end
      end
      if (cfg_we_i) cumulative_mode = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        predict_request(wis_op_e'(operation_i), weight_i, random_word_i);
      pending_o = expected_draws.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the weighted index sampler test: clock, reset, request and register
// stimulus, random result back-pressure and the verdict.
// Depends on wis_pkg, weighted_index_sampler and wis_draw_checker.
`timescale 1ns / 1ps

module testbench
  import wis_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_ITEMS = 750;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_we      = 1'b0;
  logic             cfg_wdata   = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic [1:0]       operation   = OP_CLEAR;
  logic [WT_W-1:0]  weight      = '0;
  logic [DVD_W-1:0] random_word = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic [IDX_W-1:0] chosen_index;
  logic [ST_W-1:0]  status;
  int               pending;
  int               fail_count;
  int unsigned      idle_pct      = 6;
  int unsigned      requests_sent = 0;
  int unsigned      cycle_count   = 0;
  int unsigned      climb         = 0;
  logic             mode_now      = 1'b0;

  weighted_index_sampler #(.MAX_ENTRIES(64)) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .operation_i   (operation),
    .weight_i      (weight),
    .random_word_i (random_word),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .chosen_index_o(chosen_index),
    .status_o      (status)
  );

  wis_draw_checker #(.MAX_ENTRIES(64)) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .operation_i   (operation),
    .weight_i      (weight),
    .random_word_i (random_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .chosen_index_i(chosen_index),
    .status_i      (status),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  function automatic logic [WT_W-1:0] pick_weight();
    case ($urandom_range(9))
      0:       return '0;
      1:       return {WT_W{1'b1}};
      2, 3, 4: return WT_W'($urandom_range(255, 1));
      default: return WT_W'($urandom);
    endcase
  endfunction

  function automatic logic [DVD_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return {DVD_W{1'b1}};
      2:       return DVD_W'($urandom_range(1023));
      default: return $urandom;
    endcase
  endfunction

  // mostly climbing totals in cumulative mode, now and then one out of order
  function automatic logic [WT_W-1:0] next_append();
    if (!mode_now || $urandom_range(9) == 0) return pick_weight();
    climb = climb + $urandom_range(200000);
    if (climb > 32'h00FF_FFFF) climb = 32'h00FF_FFFF;
    return WT_W'(climb);
  endfunction

  task automatic send_request(input wis_op_e op, input logic [WT_W-1:0] w,
                              input logic [DVD_W-1:0] rw);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    weight      <= w;
    random_word <= rw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic write_mode(input logic v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    mode_now = v;
  endtask

  task automatic run_sequence(input int unsigned appends);
    if ($urandom_range(3) != 0) begin
      send_request(OP_CLEAR, pick_weight(), pick_word());
      climb = 0;
    end
    repeat (appends) send_request(OP_APPEND, next_append(), pick_word());
    repeat ($urandom_range(12, 2)) send_request(OP_DRAW, pick_weight(), pick_word());
  endtask

  initial begin
    int unsigned phase_end;
    int unsigned depth;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    write_mode(1'b0);
    send_request(OP_DRAW, '0, '0);
    send_request(OP_NONE, {WT_W{1'b1}}, {DVD_W{1'b1}});
    send_request(OP_APPEND, '0, '0);
    send_request(OP_DRAW, '0, 32'd12345);
    send_request(OP_APPEND, {WT_W{1'b1}}, '0);
    send_request(OP_APPEND, 24'd1, '0);
    send_request(OP_DRAW, '0, {DVD_W{1'b1}});
    send_request(OP_DRAW, {WT_W{1'b1}}, '0);
    send_request(OP_DRAW, '0, 32'h00FF_FFFF);
    send_request(OP_CLEAR, '0, '0);
    send_request(OP_DRAW, '0, {DVD_W{1'b1}});

    write_mode(1'b1);
    send_request(OP_APPEND, 24'd100, '0);
    send_request(OP_APPEND, 24'd50, '0);
    send_request(OP_APPEND, 24'd300, '0);
    send_request(OP_DRAW, '0, 32'd99);
    send_request(OP_DRAW, '0, 32'd250);
    send_request(OP_APPEND, '0, '0);
    send_request(OP_DRAW, '0, {DVD_W{1'b1}});

    write_mode(1'b0);
    send_request(OP_APPEND, 24'd7, '0);
    send_request(OP_DRAW, '0, 32'd6);
    send_request(OP_DRAW, '0, {DVD_W{1'b1}});
    send_request(OP_CLEAR, {WT_W{1'b1}}, {DVD_W{1'b1}});

    run_sequence(66);

    for (int phase = 0; phase < 10; phase++) begin
      idle_pct = (phase == 4 || phase == 5) ? 0 : 6;
      write_mode(phase < 4 ? 1'(phase) : 1'($urandom_range(1)));
      phase_end = requests_sent + RANDOM_ITEMS / 10;
      while (requests_sent < phase_end) begin
        if ($urandom_range(7) == 0) begin
          send_request(wis_op_e'($urandom_range(3)), pick_weight(), pick_word());
        end else begin
          case ($urandom_range(19))
            0:       depth = $urandom_range(70, 65);
            1, 2, 3: depth = $urandom_range(64, 30);
            default: depth = $urandom_range(12, 1);
          endcase
          run_sequence(depth);
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
